// ===== hdl/insertion_sorter_top_assert.svh =====
// Assertion macros shared by the insertion sorter RTL.
// No dependencies; included inside module bodies after the package import.
`ifndef INSERTION_SORTER_TOP_ASSERT_SVH
`define INSERTION_SORTER_TOP_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define IST_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define IST_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ins_sort_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the insertion sorter.
// No dependencies.
package ins_sort_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
      logic               overflow;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic               insert;
      logic               shift;
      logic signed [31:0] key;
   } cell_ctrl_type;

endpackage

// ===== hdl/ins_sort_cell.sv =====
`timescale 1ns / 1ps
// One compare-and-shift cell of the sorting chain.
// Depends on ins_sort_pkg.
module ins_sort_cell (
   input  logic                        clock,
   input  ins_sort_pkg::cell_ctrl_type ctrl,
   input  logic                        occupied,
   input  logic                        left_gt,
   input  logic signed [31:0]          left_value,
   input  logic signed [31:0]          right_value,
   output logic                        gt,
   output logic signed [31:0]          value
);
   import ins_sort_pkg::*;

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // Empty cells count as greater so the key lands at the first free slot.
   // Strict compare keeps equal values in arrival order.
   assign gt = !occupied || (value_ff > ctrl.key);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && gt) begin
         value_in = left_gt ? left_value : ctrl.key;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hdl/insertion_sorter_top.sv =====
`timescale 1ns / 1ps
// Insertion sorter: controller, output register and the chain of cells.
// Depends on ins_sort_pkg, ins_sort_cell and insertion_sorter_top_assert.svh.
//
// Usage:
//   req_ carries one signed value per transfer, with last on the final one of
//   a run. Each value is inserted into the cell chain in the cycle it is
//   accepted, so loading runs at one item per cycle. Values beyond CAPACITY
//   are dropped and the run is marked overflowed.
//   After the last item the chain shifts toward cell 0 and emits one sorted
//   value per cycle on rsp_ while rsp_stall stays low, ascending, last_out on
//   the final one. The last input transfer moves the controller into the
//   drain state, which then loads the first result into the output register.
//   req_stall is high while the chain drains; the next run may start while
//   the final result still sits in the output register.
//   rsp_stall holds the output register and pauses the drain, nothing is lost.
//   Reset (synchronous) empties the chain and clears the overflow mark.
module insertion_sorter_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ins_sort_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ins_sort_pkg::rsp_type rsp_data
);
   import ins_sort_pkg::*;
   `include "insertion_sorter_top_assert.svh"

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          full;
   logic          load_out;
   cell_ctrl_type ctrl;

   logic               occ  [CAPACITY];
   logic               gt   [CAPACITY];
   logic signed [31:0] vals [CAPACITY];

   assign req_stall = (state_ff == ST_DRAIN);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign load_out  = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = load_out;
   assign ctrl.key    = req_data.value;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic               lgt;
         logic signed [31:0] lval;
         logic signed [31:0] rval;

         assign occ[i] = (CNT_W'(i) < count_ff);
         if (i == 0) begin : g_first
            assign lgt  = 1'b0;
            assign lval = vals[0];
         end else begin : g_mid
            assign lgt  = gt[i-1];
            assign lval = vals[i-1];
         end
         if (i == CAPACITY - 1) begin : g_end
            assign rval = vals[i];
         end else begin : g_inner
            assign rval = vals[i+1];
         end

         ins_sort_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_gt     (lgt),
            .left_value  (lval),
            .right_value (rval),
            .gt          (gt[i]),
            .value       (vals[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (load_out) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = vals[0];
               rsp_data_in.last_out     = (count_ff == CNT_W'(1));
               rsp_data_in.overflow     = dropped_ff;
               count_in                 = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IST_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `IST_ASSERT_IMP(a_drain_nonempty, clock, reset, state_ff == ST_DRAIN, count_ff != '0, "drain with empty chain")
   `IST_ASSERT_NXT(a_final_clears, clock, reset, load_out && (count_ff == CNT_W'(1)), (state_ff == ST_LOAD) && (count_ff == '0) && !dropped_ff && rsp_data_ff.last_out, "final result did not clear run")

endmodule

// ===== sim/insertion_sorter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter_top: drives runs of signed values and
// checks every sorted result against an in-bench run model. Depends on ins_sort_pkg.
module insertion_sorter_top_tb;
   import ins_sort_pkg::*;

   localparam int IDLE_PCT     = 23;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 140;
   localparam int TAIL_CYCLES  = 40;
   localparam int REPORT_MAX   = 10;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   // Holds the run being loaded and the sorted values still owed by the block.
   class sorted_run_board;
      logic signed [31:0] store [CAPACITY];
      int unsigned        fill;
      bit                 dropped;
      rsp_type            sorted_due[$];
      int unsigned        mismatches;

      function new();
         fill       = 0;
         dropped    = 0;
         mismatches = 0;
      endfunction

      function void note_value(input req_type d);
         int unsigned pos;
         rsp_type     r;
         if (fill < CAPACITY) begin
            pos = fill;
            // strictly greater moves up, so equal values keep arrival order
            while (pos > 0 && store[pos-1] > d.value) begin
               store[pos] = store[pos-1];
               pos--;
            end
            store[pos] = d.value;
            fill++;
         end else begin
            dropped = 1;
         end
         if (d.last) begin
            for (int unsigned k = 0; k < fill; k++) begin
               r.sorted_value = store[k];
               r.last_out     = (k + 1 == fill);
               r.overflow     = dropped;
               sorted_due.push_back(r);
            end
            fill    = 0;
            dropped = 0;
         end
      endfunction

      function void check_sorted(input rsp_type got);
         rsp_type want;
         if (sorted_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result value=%0d last_out=%0b overflow=%0b",
                        $time, got.sorted_value, got.last_out, got.overflow);
            return;
         end
         want = sorted_due.pop_front();
         if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out ||
             got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: mismatch value exp=%0d got=%0d last_out exp=%0b got=%0b %s",
                        $time, want.sorted_value, got.sorted_value, want.last_out,
                        got.last_out, $sformatf("overflow exp=%0b got=%0b",
                        want.overflow, got.overflow));
         end
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sorted_run_board board = new();
   bit calm;           // no idling on either side while set
   bit hold_off_req;   // asks the receiver for one long stall
   int quiet_cycles;

   insertion_sorter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_sorted(rsp_data);
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic signed [31:0] v, input logic lst);
      req_type d;
      d.value = v;
      d.last  = lst;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      board.note_value(d);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(3))
         0: return $signed($urandom_range(8)) - 4;    // dense duplicates
         1: case ($urandom_range(3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int unsigned sent;
      int unsigned run_len;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      calm         = 0;
      hold_off_req = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-item runs at both extremes
      send_item(VAL_MIN, 1'b1);
      send_item(VAL_MAX, 1'b1);
      // signed order, extremes and equal values in one run
      send_item(VAL_MAX, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(VAL_MIN, 1'b0);
      send_item(32'sd0, 1'b1);
      // one past capacity: last value is dropped and the run is overflowed
      for (int i = 0; i <= CAPACITY; i++)
         send_item($signed(i % 5) - 2, i == CAPACITY);

      // random runs; long receiver hold-off while the sender keeps going
      hold_off_req = 1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0)
            run_len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
         else
            run_len = $urandom_range(CAPACITY, 1);
         for (int unsigned i = 0; i < run_len; i++) begin
            calm = (sent >= 60 && sent < 110);
            send_item(pick_value(), i + 1 == run_len);
            sent++;
         end
      end
      calm = 0;
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.pending() != 0)
         $display("%0d expected results never arrived", board.pending());
      if (board.mismatches == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
